### src/siph_pkg.sv
// ----------------------------------------------------------------------------
// siph_pkg
// Shared types, constants and round functions for the SipHash-2-4 word stream.
// ----------------------------------------------------------------------------
package siph_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned PADDR_W = 4;

  localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  // register select, taken from paddr[3] (8-byte register stride)
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } lanes_t;

  // lanes plus word count handed to the finalization pipe
  typedef struct packed {
    lanes_t           lanes;
    logic [CNT_W-1:0] count;
  } fin_req_t;

  typedef struct packed {
    logic s1_v;
    logic s2_v;
    logic s3_v;
  } fin_status_t;

  function automatic lanes_t sip_round(input lanes_t s);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    lanes_t            r;
    a = s.v0;
    b = s.v1;
    c = s.v2;
    d = s.v3;
    a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a; a = {a[31:0], a[63:32]};
    c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
    a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
    c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c; c = {c[31:0], c[63:32]};
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

  function automatic lanes_t sip_two_rounds(input lanes_t s);
    return sip_round(sip_round(s));
  endfunction

  function automatic lanes_t sip_absorb(input lanes_t s, input logic [WORD_W-1:0] m);
    lanes_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = sip_two_rounds(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

  function automatic lanes_t lanes_init(input logic [WORD_W-1:0] k0,
                                        input logic [WORD_W-1:0] k1);
    lanes_t t;
    t.v0 = k0 ^ IV0;
    t.v1 = k1 ^ IV1;
    t.v2 = k0 ^ IV2;
    t.v3 = k1 ^ IV3;
    return t;
  endfunction

endpackage

### src/siphash_word_stream_unit.sv
// ----------------------------------------------------------------------------
// siphash_word_stream_unit
// Keyed SipHash-2-4 over messages of whole 64-bit little-endian words.
//
//   channel  | ports                                   | beat when
//   ---------+-----------------------------------------+---------------------
//   input    | in_msg_word, in_has_word, in_is_last    | in_valid & in_ready
//   result   | out_digest                              | out_valid & out_ready
//   config   | psel/penable/pwrite/paddr/pwdata/prdata | psel & penable & pwrite
//
// One input beat per cycle while in_ready is high: each word gets its two
// rounds in the accept cycle. A last beat enters a three-stage finalization
// pipe (s1, s2, s3); the digest then passes into the output register.
// in_ready drops only when the finalization pipe and output register are all
// full and out_ready is low. Reset (rst_n, sync) closes any open message and
// clears the keys; no clearing pass is needed.
// ----------------------------------------------------------------------------
module siphash_word_stream_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [siph_pkg::WORD_W-1:0]  in_msg_word,
  input  logic                         in_has_word,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [siph_pkg::WORD_W-1:0]  out_digest,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [siph_pkg::PADDR_W-1:0] paddr,
  input  logic [siph_pkg::WORD_W-1:0]  pwdata,
  output logic [siph_pkg::WORD_W-1:0]  prdata,
  output logic                         pready
);
  import siph_pkg::*;

  logic [WORD_W-1:0] key_low;
  logic [WORD_W-1:0] key_high;
  logic              in_acc;
  logic              fin_push;
  logic              fin_ready;
  fin_req_t          fin_req;
  fin_status_t       fin_st;

  assign in_ready = fin_ready;
  assign in_acc   = in_valid & in_ready;

  siph_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_low  (key_low),
    .key_high (key_high)
  );

  siph_absorb u_absorb (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .msg_word (in_msg_word),
    .has_word (in_has_word),
    .is_last  (in_is_last),
    .key_low  (key_low),
    .key_high (key_high),
    .fin_push (fin_push),
    .fin_req  (fin_req)
  );

  siph_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fin_push),
    .req        (fin_req),
    .push_ready (fin_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_digest (out_digest),
    .status     (fin_st)
  );

  // a last beat always lands in the first finalization stage
  a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_is_last) |=> fin_st.s1_v)
    else $error("last beat did not enter finalization pipe");

  // input stalls only when the whole result path is backed up
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (fin_st.s1_v && fin_st.s2_v && fin_st.s3_v && out_valid && !out_ready))
    else $error("input stalled with room in the result path");

  // a new digest comes only out of the last stage
  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fin_st.s3_v))
    else $error("digest appeared without a finished stage");

endmodule

### src/siph_cfg.sv
// ----------------------------------------------------------------------------
// siph_cfg
// APB-style register file holding the two 64-bit key words.
// ----------------------------------------------------------------------------
module siph_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [siph_pkg::PADDR_W-1:0] paddr,
  input  logic [siph_pkg::WORD_W-1:0]  pwdata,
  output logic [siph_pkg::WORD_W-1:0]  prdata,
  output logic                         pready,
  output logic [siph_pkg::WORD_W-1:0]  key_low,
  output logic [siph_pkg::WORD_W-1:0]  key_high
);
  import siph_pkg::*;

  logic [WORD_W-1:0] key_low_r;
  logic [WORD_W-1:0] key_high_r;
  logic              reg_sel;
  logic              wr_en;

  assign reg_sel = paddr[3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_KEY_HIGH: key_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = key_high_r;
      default:      prdata = '0;
    endcase
  end

  assign key_low  = key_low_r;
  assign key_high = key_high_r;

endmodule

### src/siph_absorb.sv
// ----------------------------------------------------------------------------
// siph_absorb
// Lane state and word count; mixes one message word (two rounds) per beat that carries a word.
// ----------------------------------------------------------------------------
module siph_absorb (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [siph_pkg::WORD_W-1:0] msg_word,
  input  logic                        has_word,
  input  logic                        is_last,
  input  logic [siph_pkg::WORD_W-1:0] key_low,
  input  logic [siph_pkg::WORD_W-1:0] key_high,
  output logic                        fin_push,
  output siph_pkg::fin_req_t          fin_req
);
  import siph_pkg::*;

  lanes_t           lanes_r;
  lanes_t           lanes_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             open_r;
  lanes_t           base;
  logic [CNT_W-1:0] cnt_base;

  // a closed message starts fresh from the current key
  always_comb begin
    base      = open_r ? lanes_r : lanes_init(key_low, key_high);
    cnt_base  = open_r ? count_r : '0;
    lanes_nxt = has_word ? sip_absorb(base, msg_word) : base;
    count_nxt = cnt_base + CNT_W'(has_word);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      count_r <= '0;
    end else if (acc) begin
      open_r  <= ~is_last;
      count_r <= is_last ? '0 : count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign fin_push      = acc & is_last;
  assign fin_req.lanes = lanes_nxt;
  assign fin_req.count = count_nxt;

endmodule

### src/siph_final.sv
// ----------------------------------------------------------------------------
// siph_final
// Finalization pipe: length block, 0xff and four rounds over three stages,
// then the folded digest in the output register.
// ----------------------------------------------------------------------------
module siph_final (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  siph_pkg::fin_req_t          req,
  output logic                        push_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [siph_pkg::WORD_W-1:0] out_digest,
  output siph_pkg::fin_status_t       status
);
  import siph_pkg::*;

  fin_req_t          s1_r;
  lanes_t            s2_r;
  lanes_t            s3_r;
  logic [WORD_W-1:0] dig_r;
  logic              s1_v_r;
  logic              s2_v_r;
  logic              s3_v_r;
  logic              out_v_r;

  logic              out_free;
  logic              s3_free;
  logic              s2_free;
  logic              s1_free;
  lanes_t            s2_nxt;
  lanes_t            s3_nxt;
  lanes_t            fin_lanes;
  logic [WORD_W-1:0] dig_nxt;
  logic [WORD_W-1:0] len_blk;

  // a stage may load when it is empty or its content moves on this cycle
  assign out_free   = ~out_v_r | out_ready;
  assign s3_free    = ~s3_v_r | out_free;
  assign s2_free    = ~s2_v_r | s3_free;
  assign s1_free    = ~s1_v_r | s2_free;
  assign push_ready = s1_free;

  always_comb begin
    // byte count mod 256 in the top byte
    len_blk   = {s1_r.count, 3'b000, 56'd0};
    s2_nxt    = sip_absorb(s1_r.lanes, len_blk);
    s2_nxt.v2 = s2_nxt.v2 ^ FINAL_XOR;
    s3_nxt    = sip_two_rounds(s2_r);
    fin_lanes = sip_two_rounds(s3_r);
    dig_nxt   = fin_lanes.v0 ^ fin_lanes.v1 ^ fin_lanes.v2 ^ fin_lanes.v3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= push | (s1_v_r & ~s2_free);
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_free) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_r <= req;
    end
    if (s2_free) begin
      s2_r <= s2_nxt;
    end
    if (s3_free) begin
      s3_r <= s3_nxt;
    end
    if (out_free) begin
      dig_r <= dig_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_digest  = dig_r;
  assign status.s1_v = s1_v_r;
  assign status.s2_v = s2_v_r;
  assign status.s3_v = s3_v_r;

endmodule

### dv/siphash_word_stream_unit_tb.sv
// ----------------------------------------------------------------------------
// siphash_word_stream_unit_tb
// Self-checking bench for the SipHash-2-4 word stream unit. A directed table
// (standard test vectors, field extremes, end markers, idle beats, key change
// inside an open message) is followed by random messages of whole words under
// several keys. Digests are checked against a bench-side SipHash model; both
// channels idle and stall at random, with long receiver hold-offs.
// ----------------------------------------------------------------------------
module siphash_word_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import siph_pkg::*;

  localparam int RND_BEATS   = 1300;
  localparam int IDLE_GAP    = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 500000;
  localparam int N_DIR       = 19;

  typedef struct packed {
    logic [1:0]        key_idx;
    logic [WORD_W-1:0] word;
    logic              has;
    logic              last;
    logic              known;
    logic [WORD_W-1:0] digest;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [WORD_W-1:0]   in_msg_word;
  logic                in_has_word;
  logic                in_is_last;
  logic                out_valid;
  logic                out_ready;
  logic [WORD_W-1:0]   out_digest;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [WORD_W-1:0]   pwdata;
  logic [WORD_W-1:0]   prdata;
  logic                pready;

  siphash_word_stream_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_msg_word (in_msg_word),
    .in_has_word (in_has_word),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_digest  (out_digest),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // bench copy of the hash state and keys
  logic [WORD_W-1:0] hv [0:3];
  logic [CNT_W-1:0]  wcnt;
  logic              msg_open;
  logic [WORD_W-1:0] key_lo;
  logic [WORD_W-1:0] key_hi;

  logic [WORD_W-1:0] digest_q [$];

  int cyc;
  int mism_cnt;
  int cfg_err_cnt;
  int dig_cnt;
  int hold_tokens;
  int hold_served;
  int hold_left;
  int rx_mode;
  int rx_cyc;
  int burst_left;

  dir_row_t          dir_rows [N_DIR];
  logic [WORD_W-1:0] key_lo_tab [4];
  logic [WORD_W-1:0] key_hi_tab [4];

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // ---------------- SipHash model ----------------
  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic void sip_mix();
    hv[0] = hv[0] + hv[1]; hv[1] = rotl64(hv[1], 13); hv[1] ^= hv[0];
    hv[0] = rotl64(hv[0], 32);
    hv[2] = hv[2] + hv[3]; hv[3] = rotl64(hv[3], 16); hv[3] ^= hv[2];
    hv[0] = hv[0] + hv[3]; hv[3] = rotl64(hv[3], 21); hv[3] ^= hv[0];
    hv[2] = hv[2] + hv[1]; hv[1] = rotl64(hv[1], 17); hv[1] ^= hv[2];
    hv[2] = rotl64(hv[2], 32);
  endfunction

  function automatic void sip_absorb_word(input logic [WORD_W-1:0] m);
    hv[3] ^= m;
    sip_mix();
    sip_mix();
    hv[0] ^= m;
  endfunction

  // advances the model by one beat; returns 1 with the digest on a last beat
  function automatic bit sip_digest_step(input logic [WORD_W-1:0] w, input logic has,
                                         input logic last, output logic [WORD_W-1:0] dg);
    dg = '0;
    if (!msg_open) begin
      hv[0]    = key_lo ^ IV0;
      hv[1]    = key_hi ^ IV1;
      hv[2]    = key_lo ^ IV2;
      hv[3]    = key_hi ^ IV3;
      wcnt     = '0;
      msg_open = 1'b1;
    end
    if (has) begin
      sip_absorb_word(w);
      wcnt = wcnt + 1'b1;
    end
    if (!last) return 1'b0;
    // length block: byte count mod 256 in the top byte
    sip_absorb_word({wcnt, 3'b000, 56'h0});
    hv[2] ^= FINAL_XOR;
    sip_mix();
    sip_mix();
    sip_mix();
    sip_mix();
    dg       = hv[0] ^ hv[1] ^ hv[2] ^ hv[3];
    msg_open = 1'b0;
    wcnt     = '0;
    return 1'b1;
  endfunction

  // ---------------- input side ----------------
  task automatic push_beat(input logic [WORD_W-1:0] w, input logic has, input logic last);
    logic [WORD_W-1:0] dg;
    in_valid    <= 1'b1;
    in_msg_word <= w;
    in_has_word <= has;
    in_is_last  <= last;
    do @(posedge clk); while (!in_ready);
    if (sip_digest_step(w, has, last, dg)) digest_q.push_back(dg);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // one APB transfer: setup, access, then a return to idle with psel low
  task automatic apb_xfer(input logic wr, input logic idx, input logic [WORD_W-1:0] wdata,
                          output logic [WORD_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1);
    logic [WORD_W-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, REG_KEY_LOW, k0, rd);
    key_lo = k0;
    apb_xfer(1'b1, REG_KEY_HIGH, k1, rd);
    key_hi = k1;
    apb_xfer(1'b0, REG_KEY_LOW, '0, rd);
    if (rd !== k0) begin
      $error("prdata key_low: expected %h, actual %h", k0, rd);
      cfg_err_cnt++;
    end
    apb_xfer(1'b0, REG_KEY_HIGH, '0, rd);
    if (rd !== k1) begin
      $error("prdata key_high: expected %h, actual %h", k1, rd);
      cfg_err_cnt++;
    end
  endtask

  task automatic next_keys(input int ph);
    case (ph % 5)
      0:       apply_keys('0, '0);
      1:       apply_keys('1, '1);
      2:       apply_keys(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      default: apply_keys({$urandom, $urandom}, {$urandom, $urandom});
    endcase
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    logic [WORD_W-1:0] exp_dg;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("digest: no beat expected, actual %h", out_digest);
        mism_cnt++;
      end else begin
        exp_dg = digest_q.pop_front();
        dig_cnt++;
        if (out_digest !== exp_dg) begin
          $error("digest: expected %h, actual %h", exp_dg, out_digest);
          mism_cnt++;
        end
      end
    end
    rx_cyc++;
    if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_tokens) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 2) == 0);
        default: out_ready <= (rx_cyc % 5 > 1);
      endcase
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int rnd_beats;
    int msg_cnt;
    int long_cnt;
    int key_cnt;
    int mid_cnt;
    int phase;
    int nwords;
    bit mid_key;
    bit sep_end;
    int cur_key;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_msg_word = '0;
    in_has_word = 1'b0;
    in_is_last  = 1'b0;
    out_ready   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_tokens = 0;
    hold_served = 0;
    hold_left   = 0;
    rx_mode     = 0;
    rx_cyc      = 0;
    cyc         = 0;
    mism_cnt    = 0;
    cfg_err_cnt = 0;
    dig_cnt     = 0;
    burst_left  = 0;
    key_lo      = '0;
    key_hi      = '0;
    msg_open    = 1'b0;
    wcnt        = '0;
    for (int i = 0; i < 4; i++) hv[i] = '0;
    rnd_beats = 0;
    msg_cnt   = 0;
    long_cnt  = 0;
    key_cnt   = 0;
    mid_cnt   = 0;
    phase     = 0;
    cur_key   = 0;

    key_lo_tab = '{64'h0, 64'h0706050403020100, 64'hffff_ffff_ffff_ffff,
                   64'haaaa_aaaa_aaaa_aaaa};
    key_hi_tab = '{64'h0, 64'h0f0e0d0c0b0a0908, 64'hffff_ffff_ffff_ffff,
                   64'h5555_5555_5555_5555};

    // key_idx, word, has, last, known, digest
    dir_rows = '{
      '{2'd0, 64'h0,                   1'b0, 1'b1, 1'b0, 64'h0},  // empty, reset key
      '{2'd0, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0, 64'h0},
      '{2'd0, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 1'b0, 64'h0},  // idle beat opens
      '{2'd0, 64'h0,                   1'b1, 1'b0, 1'b0, 64'h0},
      '{2'd0, 64'hdead_beef_dead_beef, 1'b0, 1'b0, 1'b0, 64'h0},  // idle beat, open
      '{2'd0, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 1'b0, 64'h0},  // marker, junk word
      '{2'd0, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 1'b0, 64'h0},
      '{2'd1, 64'h0,                   1'b0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
      '{2'd1, 64'h0706050403020100,    1'b1, 1'b1, 1'b1, 64'h93f5f5799a932462},
      '{2'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
      '{2'd2, 64'h0000_0000_0000_0001, 1'b1, 1'b1, 1'b0, 64'h0},  // key swapped mid-msg
      '{2'd2, 64'h0,                   1'b0, 1'b1, 1'b0, 64'h0},
      '{2'd2, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 1'b0, 64'h0},
      '{2'd2, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 1'b0, 64'h0},
      '{2'd2, 64'h0,                   1'b1, 1'b1, 1'b0, 64'h0},
      '{2'd3, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, 64'h0},
      '{2'd3, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1, 1'b0, 64'h0},
      '{2'd3, 64'h0,                   1'b0, 1'b0, 1'b0, 64'h0},
      '{2'd3, 64'h0,                   1'b0, 1'b1, 1'b0, 64'h0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].key_idx != cur_key) begin
        if (msg_open) mid_cnt++;
        cur_key = dir_rows[r].key_idx;
        apply_keys(key_lo_tab[cur_key], key_hi_tab[cur_key]);
        key_cnt++;
      end
      // return at the accept edge so the typed digest replaces the queued one
      // before it can reach the output
      if (dir_rows[r].known && burst_left == 0) burst_left = 1;
      push_beat(dir_rows[r].word, dir_rows[r].has, dir_rows[r].last);
      if (dir_rows[r].known) digest_q[digest_q.size()-1] = dir_rows[r].digest;
    end

    while (rnd_beats < RND_BEATS) begin
      mid_key = 1'b0;
      if (msg_cnt % 30 == 29) begin
        if ($urandom_range(0, 1)) begin
          mid_key = 1'b1;
        end else begin
          next_keys(phase++);
          key_cnt++;
        end
      end
      if (msg_cnt == 60 || msg_cnt == 180) hold_tokens <= hold_tokens + 1;
      if (msg_cnt == 120) wait_idle();

      nwords  = ($urandom_range(0, 99) < 6) ? $urandom_range(30, 40) : $urandom_range(0, 6);
      if (nwords >= 30) long_cnt++;
      sep_end = (nwords == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < nwords; i++) begin
        if ($urandom_range(0, 9) == 0) push_beat({$urandom, $urandom}, 1'b0, 1'b0);
        if (mid_key && i == 1) begin
          next_keys(phase++);
          key_cnt++;
          mid_cnt++;
        end
        push_beat({$urandom, $urandom}, 1'b1, !sep_end && (i == nwords - 1));
        rnd_beats++;
      end
      if (mid_key && nwords < 2) begin
        next_keys(phase++);
        key_cnt++;
      end
      if (sep_end) begin
        if ($urandom_range(0, 7) == 0) push_beat({$urandom, $urandom}, 1'b0, 1'b0);
        push_beat({$urandom, $urandom}, 1'b0, 1'b1);
        rnd_beats++;
      end
      msg_cnt++;
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Run: %0d random beats in %0d messages (%0d of 30+ words), %0d digests checked",
             rnd_beats, msg_cnt, long_cnt, dig_cnt);
    $display("Keys set %0d times (%0d with a message open), %0d long receiver hold-offs",
             key_cnt, mid_cnt, hold_served);
    if (mism_cnt == 0 && cfg_err_cnt == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/siph_pkg.sv
src/siph_cfg.sv
src/siph_absorb.sv
src/siph_final.sv
src/siphash_word_stream_unit.sv
dv/siphash_word_stream_unit_tb.sv
